// ===== sv/hrp_pkg.sv =====
package hrp_pkg;

    // content length width
    localparam int LENGTH_BITS_DEF = 32;

    // queue between parser and output side
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    // result kinds
    typedef enum logic [2:0] {
        KIND_URL   = 3'd0,
        KIND_QUERY = 3'd1,
        KIND_HOST  = 3'd2,
        KIND_BODY  = 3'd3,
        KIND_DONE  = 3'd4,
        KIND_ERROR = 3'd5
    } t_kind;

    // parser phases
    typedef enum logic [3:0] {
        PH_METHOD  = 4'd0,
        PH_MBLANK  = 4'd1,
        PH_URL     = 4'd2,
        PH_QUERY   = 4'd3,
        PH_VBLANK  = 4'd4,
        PH_VERSION = 4'd5,
        PH_HDR     = 4'd6,
        PH_CBLANK  = 4'd7,
        PH_CVAL    = 4'd8,
        PH_HBLANK  = 4'd9,
        PH_HOST    = 4'd10,
        PH_LBLANK  = 4'd11,
        PH_LVAL    = 4'd12,
        PH_IGNORE  = 4'd13,
        PH_BODY    = 4'd14
    } t_phase;

    // field codes
    localparam logic [1:0] METH_UNKNOWN = 2'd0;
    localparam logic [1:0] METH_GET     = 2'd1;
    localparam logic [1:0] METH_POST    = 2'd2;
    localparam logic [1:0] CONN_UNKNOWN = 2'd0;
    localparam logic [1:0] CONN_KEEP    = 2'd1;
    localparam logic [1:0] CONN_CLOSE   = 2'd2;

    // keyword indexes
    localparam logic [2:0] KW_GET   = 3'd0;
    localparam logic [2:0] KW_POST  = 3'd1;
    localparam logic [2:0] KW_HTTP  = 3'd2;
    localparam logic [2:0] KW_CONN  = 3'd3;
    localparam logic [2:0] KW_HOSTK = 3'd4;
    localparam logic [2:0] KW_CLEN  = 3'd5;
    localparam logic [2:0] KW_KEEP  = 3'd6;
    localparam logic [2:0] KW_CLOSE = 3'd7;

    // candidate masks
    localparam logic [7:0] MASK_METHOD = 8'b0000_0011;
    localparam logic [7:0] MASK_HTTP   = 8'b0000_0100;
    localparam logic [7:0] MASK_HDR    = 8'b0011_1000;
    localparam logic [7:0] MASK_CVAL   = 8'b1110_0000;
    localparam logic [7:0] MASK_CLEN   = 8'b0010_0000;

    // special bytes
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // keyword text, lower case, right aligned
    localparam logic [119:0] S_GET   = "get";
    localparam logic [119:0] S_POST  = "post";
    localparam logic [119:0] S_HTTP  = "http/1.1";
    localparam logic [119:0] S_CONN  = "connection:";
    localparam logic [119:0] S_HOST  = "host:";
    localparam logic [119:0] S_CLEN  = "content-length:";
    localparam logic [119:0] S_KEEP  = "keep-alive";
    localparam logic [119:0] S_CLOSE = "close";

    // one queued entry: up to two results from one input word
    typedef struct packed {
        logic        two;
        t_kind       kind;
        logic [7:0]  data;
        logic [1:0]  method;
        logic        version;
        logic [1:0]  conn;
        logic [31:0] blen;
    } t_pkt;

    // keyword match step outcome
    typedef struct packed {
        logic [7:0] cand;
        logic [4:0] off;
        logic       fail;
        logic       done;
        logic [2:0] kw;
    } t_match;

    // queue status toward the parser
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [4:0] kw_len(input logic [2:0] k);
        logic [4:0] len;
        case (k)
            KW_GET:   len = 5'd3;
            KW_POST:  len = 5'd4;
            KW_HTTP:  len = 5'd8;
            KW_CONN:  len = 5'd11;
            KW_HOSTK: len = 5'd5;
            KW_CLEN:  len = 5'd15;
            KW_KEEP:  len = 5'd10;
            default:  len = 5'd5;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [4:0] o);
        logic [119:0] s;
        logic [4:0]   len;
        logic [7:0]   ch;
        case (k)
            KW_GET:   s = S_GET;
            KW_POST:  s = S_POST;
            KW_HTTP:  s = S_HTTP;
            KW_CONN:  s = S_CONN;
            KW_HOSTK: s = S_HOST;
            KW_CLEN:  s = S_CLEN;
            KW_KEEP:  s = S_KEEP;
            default:  s = S_CLOSE;
        endcase
        len = kw_len(k);
        ch  = 8'h00;
        if (o < len) begin
            ch = s[8*(int'(len) - 1 - int'(o)) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    function automatic t_match match_step(input logic [7:0] cand, input logic [4:0] off,
                                          input logic [7:0] c);
        t_match     m;
        logic [7:0] lc;
        lc = to_lower(c);
        m  = '0;
        for (int k = 0; k < 8; k++) begin
            if (cand[k] && off < kw_len(3'(k)) && lc == kw_char(3'(k), off)) begin
                m.cand[k] = 1'b1;
            end
        end
        m.off  = off + 5'd1;
        m.fail = (m.cand == 8'h00);
        // lowest completed keyword wins
        for (int k = 7; k >= 0; k--) begin
            if (m.cand[k] && kw_len(3'(k)) == m.off) begin
                m.done = 1'b1;
                m.kw   = 3'(k);
            end
        end
        return m;
    endfunction

endpackage

// ===== sv/hrp_front.sv =====
module hrp_front
    import hrp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_wr,
    output t_pkt       o_pkt
);

    localparam int LW = LENGTH_BITS + 4;

    t_phase                 r_phase, n_phase;
    logic [4:0]             r_off, n_off;
    logic [7:0]             r_cand, n_cand;
    logic                   r_cr, n_cr;
    logic [1:0]             r_method, n_method;
    logic                   r_version, n_version;
    logic [1:0]             r_conn, n_conn;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;

    t_match                 m_cur, m_ver, m_cv, mm;
    logic                   blank, space, digit;
    logic                   emit, two, clear;
    t_kind                  e_kind;
    logic [7:0]             e_data;
    logic                   do_url, url_q, do_ver, ver_new, do_hdr;
    logic                   do_cval, cval_new, do_host, do_lval;
    logic [LW-1:0]          len_x10;
    logic [LW-1:0]          len_max;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [LENGTH_BITS+31:0] len_ext;

    // byte classes and keyword steps
    assign blank   = (i_byte == CH_SP) || (i_byte == CH_TAB);
    assign space   = (i_byte == CH_SP) || (i_byte >= 8'd9 && i_byte <= 8'd13);
    assign digit   = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign m_cur   = match_step(r_cand, r_off, i_byte);
    assign m_ver   = match_step(MASK_HTTP, 5'd0, i_byte);
    assign m_cv    = match_step(MASK_CVAL, 5'd0, i_byte);
    assign len_x10 = (LW'(r_len) << 3) + (LW'(r_len) << 1) + LW'(i_byte - 8'h30);
    assign len_max = LW'({LENGTH_BITS{1'b1}});
    assign rem_dec = (r_rem != '0) ? r_rem - 1'b1 : '0;
    assign len_ext = {32'b0, r_len};

    // next parser state
    always_comb begin
        n_phase   = r_phase;
        n_off     = r_off;
        n_cand    = r_cand;
        n_cr      = r_cr;
        n_method  = r_method;
        n_version = r_version;
        n_conn    = r_conn;
        n_len     = r_len;
        n_rem     = r_rem;
        emit      = 1'b0;
        two       = 1'b0;
        clear     = 1'b0;
        e_kind    = KIND_ERROR;
        e_data    = 8'h00;
        do_url    = 1'b0;
        url_q     = 1'b0;
        do_ver    = 1'b0;
        ver_new   = 1'b0;
        do_hdr    = 1'b0;
        do_cval   = 1'b0;
        cval_new  = 1'b0;
        do_host   = 1'b0;
        do_lval   = 1'b0;
        mm        = m_cur;

        if (r_phase == PH_BODY) begin
            emit   = 1'b1;
            e_kind = KIND_BODY;
            e_data = i_byte;
            n_rem  = rem_dec;
            if (rem_dec == '0) begin
                two   = 1'b1;
                clear = 1'b1;
            end
        end else if (r_cr) begin
            if (i_byte == CH_LF) begin
                n_cr = 1'b0;
                if (r_phase == PH_HDR && r_off == 5'd0) begin
                    if (r_method == METH_GET || r_len == '0) begin
                        emit   = 1'b1;
                        e_kind = KIND_DONE;
                        clear  = 1'b1;
                    end else begin
                        n_rem   = r_len;
                        n_phase = PH_BODY;
                    end
                end else begin
                    n_phase = PH_HDR;
                    n_cand  = MASK_HDR;
                    n_off   = 5'd0;
                end
            end else begin
                emit  = 1'b1;
                clear = 1'b1;
            end
        end else if (i_byte == CH_LF) begin
            emit  = 1'b1;
            clear = 1'b1;
        end else if (i_byte == CH_CR) begin
            n_cr = 1'b1;
        end else begin
            // dispatch, including blank-skip redirects
            case (r_phase)
                PH_METHOD: begin
                    n_cand = m_cur.cand;
                    n_off  = m_cur.off;
                    if (m_cur.done && (m_cur.kw == KW_GET || m_cur.kw == KW_POST)) begin
                        n_method = (m_cur.kw == KW_GET) ? METH_GET : METH_POST;
                        n_phase  = PH_MBLANK;
                    end else if (m_cur.fail) begin
                        do_url = 1'b1;
                    end
                end
                PH_MBLANK:  do_url = !blank;
                PH_URL:     do_url = 1'b1;
                PH_QUERY: begin
                    do_url = 1'b1;
                    url_q  = 1'b1;
                end
                PH_VBLANK: begin
                    do_ver  = !blank;
                    ver_new = 1'b1;
                end
                PH_VERSION: do_ver = 1'b1;
                PH_HDR:     do_hdr = 1'b1;
                PH_CBLANK: begin
                    do_cval  = !blank;
                    cval_new = 1'b1;
                end
                PH_CVAL:    do_cval = 1'b1;
                PH_HBLANK:  do_host = !blank;
                PH_HOST:    do_host = 1'b1;
                PH_LBLANK:  do_lval = !blank;
                PH_LVAL:    do_lval = 1'b1;
                default:    ;
            endcase

            // url and query bytes
            if (do_url) begin
                if (blank) begin
                    n_phase = PH_VBLANK;
                end else if (i_byte == CH_QMARK || url_q) begin
                    n_phase = PH_QUERY;
                    emit    = 1'b1;
                    e_kind  = KIND_QUERY;
                    e_data  = i_byte;
                end else begin
                    n_phase = PH_URL;
                    emit    = 1'b1;
                    e_kind  = KIND_URL;
                    e_data  = i_byte;
                end
            end

            // version keyword
            if (do_ver) begin
                mm      = ver_new ? m_ver : m_cur;
                n_cand  = mm.cand;
                n_off   = mm.off;
                n_phase = PH_VERSION;
                if (mm.done) begin
                    n_version = 1'b1;
                    n_phase   = PH_IGNORE;
                end else if (mm.fail) begin
                    n_phase = PH_IGNORE;
                end
            end

            // header name keyword
            if (do_hdr) begin
                n_cand = m_cur.cand;
                n_off  = m_cur.off;
                if (m_cur.done && m_cur.kw == KW_CONN) begin
                    n_phase = PH_CBLANK;
                end else if (m_cur.done && m_cur.kw == KW_HOSTK) begin
                    n_phase = PH_HBLANK;
                end else if (m_cur.done && m_cur.kw == KW_CLEN) begin
                    n_len   = '0;
                    n_phase = PH_LBLANK;
                end else if (m_cur.done || m_cur.fail) begin
                    n_phase = PH_IGNORE;
                end
            end

            // connection value keyword
            if (do_cval) begin
                mm      = cval_new ? m_cv : m_cur;
                n_cand  = mm.cand;
                n_off   = mm.off;
                n_phase = PH_CVAL;
                if (mm.done && (mm.kw == KW_KEEP || mm.kw == KW_CLOSE)) begin
                    n_conn = (mm.kw == KW_KEEP) ? CONN_KEEP : CONN_CLOSE;
                    n_cand = MASK_CLEN;
                    n_off  = 5'd0;
                end else if (mm.done && mm.kw == KW_CLEN) begin
                    n_len   = '0;
                    n_phase = PH_LBLANK;
                end else if (mm.done || mm.fail) begin
                    n_phase = PH_IGNORE;
                end
            end

            // host value bytes
            if (do_host) begin
                if (space) begin
                    n_phase = PH_IGNORE;
                end else begin
                    n_phase = PH_HOST;
                    emit    = 1'b1;
                    e_kind  = KIND_HOST;
                    e_data  = i_byte;
                end
            end

            // length digits, saturating
            if (do_lval) begin
                if (digit) begin
                    n_phase = PH_LVAL;
                    n_len   = (len_x10 > len_max) ? {LENGTH_BITS{1'b1}}
                                                  : len_x10[LENGTH_BITS-1:0];
                end else begin
                    n_phase = PH_IGNORE;
                end
            end
        end

        // end of request or line error
        if (clear) begin
            n_phase   = PH_METHOD;
            n_cand    = MASK_METHOD;
            n_off     = 5'd0;
            n_cr      = 1'b0;
            n_method  = METH_UNKNOWN;
            n_version = 1'b0;
            n_conn    = CONN_UNKNOWN;
            n_len     = '0;
            n_rem     = '0;
        end
    end

    // queue word, fields as held before this byte
    always_comb begin
        o_wr          = i_accept && emit;
        o_pkt.two     = two;
        o_pkt.kind    = e_kind;
        o_pkt.data    = e_data;
        o_pkt.method  = r_method;
        o_pkt.version = r_version;
        o_pkt.conn    = r_conn;
        o_pkt.blen    = len_ext[31:0];
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_METHOD;
            r_off     <= 5'd0;
            r_cand    <= MASK_METHOD;
            r_cr      <= 1'b0;
            r_method  <= METH_UNKNOWN;
            r_version <= 1'b0;
            r_conn    <= CONN_UNKNOWN;
            r_len     <= '0;
            r_rem     <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_off     <= n_off;
            r_cand    <= n_cand;
            r_cr      <= n_cr;
            r_method  <= n_method;
            r_version <= n_version;
            r_conn    <= n_conn;
            r_len     <= n_len;
            r_rem     <= n_rem;
        end
    end

endmodule

// ===== sv/hrp_queue.sv =====
module hrp_queue
    import hrp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_pkt   i_pkt,
    input  logic   i_rd,
    output t_pkt   o_pkt,
    output t_qstat o_stat
);

    t_pkt            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [Q_CW-1:0] r_cnt, n_cnt;
    logic            wr_ok, rd_ok;

    // status and head word
    assign o_stat.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_pkt        = r_mem[r_rp];
    assign wr_ok        = i_wr && !o_stat.full;
    assign rd_ok        = i_rd && !o_stat.empty;

    // pointer update
    always_comb begin
        n_wp  = wr_ok ? r_wp + 1'b1 : r_wp;
        n_rp  = rd_ok ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + Q_CW'(wr_ok) - Q_CW'(rd_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_pkt;
        end
    end

endmodule

// ===== sv/hrp_back.sv =====
module hrp_back
    import hrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pkt        i_pkt,
    input  t_qstat      i_stat,
    input  logic        i_pop,
    output logic        o_rd,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data,
    output logic [1:0]  o_method,
    output logic        o_version,
    output logic [1:0]  o_connection,
    output logic [31:0] o_body_length,
    output logic        o_last
);

    logic r_second, n_second;
    logic take;

    // a two-result entry gives its body word, then the done word
    assign take = i_pop && !i_stat.empty;
    assign o_rd = take && (!i_pkt.two || r_second);

    always_comb begin
        n_second = r_second;
        if (take) begin
            n_second = i_pkt.two && !r_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
        end
    end

    // result word
    always_comb begin
        o_kind        = r_second ? KIND_DONE : i_pkt.kind;
        o_data        = r_second ? 8'h00 : i_pkt.data;
        o_method      = i_pkt.method;
        o_version     = i_pkt.version;
        o_connection  = i_pkt.conn;
        o_body_length = i_pkt.blen;
        o_last        = !i_pkt.two || r_second;
    end

endmodule

// ===== sv/http_request_parser.sv =====
// http request parser
//
// input side is a queue: drive i_in_byte with push high; the byte is taken on a
// rising edge where push is high and full is low. one byte per cycle is
// accepted while full is low.
// result side is a queue too: while empty is low, the oldest result word is on
// o_kind, o_data, o_method, o_version, o_connection, o_body_length and o_last;
// pop high on a clock edge takes it.
// each result is written into the queue on the edge that takes its byte.
// throughput: one byte per cycle while full is low. a body byte that ends the
// request gives two words from one queue entry, the body word and then the
// done word; a four-entry queue sits between the parser and the output side.
// when the receiver stalls, the queue fills and full rises; bytes that give no
// result are still parsed only when full is low.
// reset (i_rst_n low on a clock edge) empties the queue and puts the parser at
// the start of a request line with all request fields cleared.
module http_request_parser
    import hrp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data,
    output logic [1:0]  o_method,
    output logic        o_version,
    output logic [1:0]  o_connection,
    output logic [31:0] o_body_length,
    output logic        o_last
);

    t_pkt   f_pkt, q_pkt;
    logic   f_wr, q_rd;
    t_qstat q_stat;

    assign full  = q_stat.full;
    assign empty = q_stat.empty;

    // parser
    hrp_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(push && !q_stat.full),
        .i_byte  (i_in_byte),
        .o_wr    (f_wr),
        .o_pkt   (f_pkt)
    );

    // decoupling queue
    hrp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (f_wr),
        .i_pkt  (f_pkt),
        .i_rd   (q_rd),
        .o_pkt  (q_pkt),
        .o_stat (q_stat)
    );

    // result output
    hrp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pkt        (q_pkt),
        .i_stat       (q_stat),
        .i_pop        (pop),
        .o_rd         (q_rd),
        .o_kind       (o_kind),
        .o_data       (o_data),
        .o_method     (o_method),
        .o_version    (o_version),
        .o_connection (o_connection),
        .o_body_length(o_body_length),
        .o_last       (o_last)
    );

endmodule

// ===== sv/hrp_checker.sv =====
module hrp_checker
    import hrp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  i_in_byte,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_data,
    input logic [1:0]  o_method,
    input logic        o_version,
    input logic [1:0]  o_connection,
    input logic [31:0] o_body_length,
    input logic        o_last
);

    // kind code in range
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_kind <= 3'(KIND_ERROR)))
        else $error("result kind out of range");

    // done and error words carry no byte and close their input word
    a_ctrl_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == 3'(KIND_DONE) || o_kind == 3'(KIND_ERROR)))
        |-> (o_data == 8'h00 && o_last))
        else $error("done or error word malformed");

    // only a body byte can be followed by a second word
    a_first_of_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last) |-> (o_kind == 3'(KIND_BODY)))
        else $error("non-last word is not a body byte");

    // after a popped non-last word the done word follows
    a_pair_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last) |=> (!empty && o_kind == 3'(KIND_DONE)))
        else $error("body word not followed by done");

endmodule

bind http_request_parser hrp_checker u_chk (.*);
